FILE: src/kplpd_pkg.sv
package kplpd_pkg;

  // Default of the key lane count.
  localparam int KEY_COUNT_DEF = 4;

  // Widths of the timing counters and thresholds.
  localparam int PRESCALE_W = 8;
  localparam int HOLD_W     = 8;
  localparam int FAST_W     = 10;
  localparam int SLOW_W     = 16;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [PRESCALE_W-1:0] SLOW_TICK_DIV_RST = 8'd10;
  localparam logic [HOLD_W-1:0]     BOUNCE_RST        = 8'd5;
  localparam logic [HOLD_W-1:0]     LONG_PRESS_RST    = 8'd200;
  localparam logic [FAST_W-1:0]     FAST_DIV_RST      = 10'd100;
  localparam logic [SLOW_W-1:0]     SLOW_DIV_RST      = 16'd1000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOW_TICK_DIV = 3'd0,
    REG_BOUNCE        = 3'd1,
    REG_LONG_PRESS    = 3'd2,
    REG_FAST_DIV      = 3'd3,
    REG_SLOW_DIV      = 3'd4
  } cfg_reg_t;

  // What one key lane reports for the current tick.
  typedef struct packed {
    logic short_press;
    logic long_press;
    logic idle;
  } lane_res_t;

endpackage

FILE: src/kplpd_divider.sv
module kplpd_divider
  import kplpd_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] limit,
  output logic         fire
);

  logic [W-1:0] count_r;
  logic [W-1:0] count_nxt;
  logic [W-1:0] count_inc;

  // Count up with wrap; fire and restart once the limit is reached or passed.
  always_comb begin
    count_inc = count_r + W'(1);
    fire      = (count_inc >= limit);
    count_nxt = fire ? '0 : count_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (en) begin
      count_r <= count_nxt;
    end
  end

endmodule

FILE: src/kplpd_lane.sv
module kplpd_lane
  import kplpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              key_edge,
  input  logic              key_released,
  input  logic              slow_tick,
  input  logic [HOLD_W-1:0] bounce_ticks,
  input  logic [HOLD_W-1:0] long_press_ticks,
  output lane_res_t         res
);

  logic              armed_r;
  logic              armed_nxt;
  logic [HOLD_W-1:0] hold_r;
  logic [HOLD_W-1:0] hold_nxt;
  logic              armed_now;
  logic [HOLD_W-1:0] hold_inc;

  // Arm on an edge, then judge the hold time on each slow tick.
  always_comb begin
    armed_now       = armed_r | key_edge;
    hold_inc        = (hold_r == '1) ? hold_r : hold_r + HOLD_W'(1);
    armed_nxt       = armed_now;
    hold_nxt        = hold_r;
    res.short_press = 1'b0;
    res.long_press  = 1'b0;
    if (slow_tick && armed_now) begin
      hold_nxt = hold_inc;
      if (hold_inc > bounce_ticks) begin
        if (key_released && (hold_inc < long_press_ticks)) begin
          res.short_press = 1'b1;
          armed_nxt       = 1'b0;
          hold_nxt        = '0;
        end else if (hold_inc >= long_press_ticks) begin
          res.long_press = 1'b1;
          armed_nxt      = 1'b0;
          hold_nxt       = '0;
        end
      end else if ((hold_inc == bounce_ticks) && key_released) begin
        // Released right at the bounce point: a glitch, dropped silently.
        armed_nxt = 1'b0;
        hold_nxt  = '0;
      end
    end
    res.idle = ~armed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      hold_r  <= '0;
    end else if (en) begin
      armed_r <= armed_nxt;
      hold_r  <= hold_nxt;
    end
  end

endmodule

FILE: src/kplpd_out_stage.sv
module kplpd_out_stage
  import kplpd_pkg::*;
#(
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              can_push,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata
);

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              skid_valid_r;
  logic [DATA_W-1:0] skid_data_r;
  logic              pop;

  assign pop        = out_valid_r & out_tready;
  assign can_push   = ~skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Output register with a skid entry that catches a transaction during a stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_r  <= push_data;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= push_data;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

FILE: src/key_press_long_press_detector_core.sv
// Short and long key-press detector for KEY_COUNT keys with two blink dividers.
// Each input transaction is one base tick and produces exactly one result
// transaction, registered in the output or skid entry. A new tick is taken in
// every cycle while in_tready is high: all keys are judged side by side in one
// lane each, and the three dividers are plain counters, so nothing inside
// limits the rate to less than one transaction per clock. A two-entry output
// stage keeps in_tready high while the output entry stalls until the skid entry
// fills; in_tready drops only while both entries hold results. Configuration
// writes are taken in every cycle and must be made while no tick is in flight.
module key_press_long_press_detector_core
  import kplpd_pkg::*;
#(
  parameter int KEY_COUNT = KEY_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Fields from bit 0 up: key_edge, key_released (KEY_COUNT bits each), pad.
  input  logic [((2*KEY_COUNT+7)/8)*8-1:0]      in_tdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // Fields from bit 0 up: short_press, long_press, edge_enabled
  // (KEY_COUNT bits each), fast_blink, slow_blink, pad.
  output logic [((3*KEY_COUNT+2+7)/8)*8-1:0]    out_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [CFG_DATA_W-1:0]                 cfg_data
);

  localparam int RAW_W = 3*KEY_COUNT+2;
  localparam int OUT_W = ((RAW_W+7)/8)*8;

  logic [PRESCALE_W-1:0] slow_tick_div_r;
  logic [HOLD_W-1:0]     bounce_r;
  logic [HOLD_W-1:0]     long_press_r;
  logic [FAST_W-1:0]     fast_div_r;
  logic [SLOW_W-1:0]     slow_div_r;

  logic                  accept;
  logic                  slow_tick;
  logic                  fast_fire;
  logic                  slow_fire;
  logic                  fast_level_r;
  logic                  fast_level_nxt;
  logic                  slow_level_r;
  logic                  slow_level_nxt;
  logic [KEY_COUNT-1:0]  key_edge;
  logic [KEY_COUNT-1:0]  key_released;
  logic [KEY_COUNT-1:0]  short_press;
  logic [KEY_COUNT-1:0]  long_press;
  logic [KEY_COUNT-1:0]  edge_enabled;
  lane_res_t             lane_res [KEY_COUNT];
  logic [OUT_W-1:0]      result;
  logic                  can_push;

  assign cfg_ready    = 1'b1;
  assign key_edge     = in_tdata[KEY_COUNT-1:0];
  assign key_released = in_tdata[2*KEY_COUNT-1:KEY_COUNT];
  assign in_tready    = can_push;
  assign accept       = in_tvalid & can_push;

  // Configuration registers; writes to an unknown index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_tick_div_r <= SLOW_TICK_DIV_RST;
      bounce_r        <= BOUNCE_RST;
      long_press_r    <= LONG_PRESS_RST;
      fast_div_r      <= FAST_DIV_RST;
      slow_div_r      <= SLOW_DIV_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SLOW_TICK_DIV: slow_tick_div_r <= cfg_data[PRESCALE_W-1:0];
        REG_BOUNCE:        bounce_r        <= cfg_data[HOLD_W-1:0];
        REG_LONG_PRESS:    long_press_r    <= cfg_data[HOLD_W-1:0];
        REG_FAST_DIV:      fast_div_r      <= cfg_data[FAST_W-1:0];
        REG_SLOW_DIV:      slow_div_r      <= cfg_data[SLOW_W-1:0];
        default: ;
      endcase
    end
  end

  // Prescaler for the key timing, and the two blink dividers.
  kplpd_divider #(.W(PRESCALE_W)) u_prescale (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (accept),
    .limit (slow_tick_div_r),
    .fire  (slow_tick)
  );

  kplpd_divider #(.W(FAST_W)) u_fast_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (accept),
    .limit (fast_div_r),
    .fire  (fast_fire)
  );

  kplpd_divider #(.W(SLOW_W)) u_slow_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (accept),
    .limit (slow_div_r),
    .fire  (slow_fire)
  );

  // Blink levels toggle when their divider fires.
  assign fast_level_nxt = fast_level_r ^ fast_fire;
  assign slow_level_nxt = slow_level_r ^ slow_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_level_r <= 1'b0;
      slow_level_r <= 1'b0;
    end else if (accept) begin
      fast_level_r <= fast_level_nxt;
      slow_level_r <= slow_level_nxt;
    end
  end

  // One lane per key.
  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
    kplpd_lane u_lane (
      .clk              (clk),
      .rst_n            (rst_n),
      .en               (accept),
      .key_edge         (key_edge[k]),
      .key_released     (key_released[k]),
      .slow_tick        (slow_tick),
      .bounce_ticks     (bounce_r),
      .long_press_ticks (long_press_r),
      .res              (lane_res[k])
    );
    assign short_press[k]  = lane_res[k].short_press;
    assign long_press[k]   = lane_res[k].long_press;
    assign edge_enabled[k] = lane_res[k].idle;
  end

  // Merge the lane findings and blink levels into one result word.
  always_comb begin
    result                            = '0;
    result[KEY_COUNT-1:0]             = short_press;
    result[2*KEY_COUNT-1:KEY_COUNT]   = long_press;
    result[3*KEY_COUNT-1:2*KEY_COUNT] = edge_enabled;
    result[3*KEY_COUNT]               = fast_level_nxt;
    result[3*KEY_COUNT+1]             = slow_level_nxt;
  end

  kplpd_out_stage #(.DATA_W(OUT_W)) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (result),
    .can_push   (can_push),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: src/kplpd_checker.sv
module kplpd_checker
  import kplpd_pkg::*;
#(
  parameter int KEY_COUNT = KEY_COUNT_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tready,
  input logic [((3*KEY_COUNT+2+7)/8)*8-1:0] out_tdata,
  input logic                               out_tvalid,
  input logic                               out_tready
);

  logic [KEY_COUNT-1:0] short_bits;
  logic [KEY_COUNT-1:0] long_bits;
  logic [KEY_COUNT-1:0] idle_bits;

  assign short_bits = out_tdata[KEY_COUNT-1:0];
  assign long_bits  = out_tdata[2*KEY_COUNT-1:KEY_COUNT];
  assign idle_bits  = out_tdata[3*KEY_COUNT-1:2*KEY_COUNT];

  // A stalled result transaction holds its data.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Input backpressure only happens while a result is waiting.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  // A key never reports a short and a long press in the same tick.
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (short_bits & long_bits) == '0)
    else $error("short and long press on one key");

  // A reported press leaves its key idle.
  a_press_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((short_bits | long_bits) & ~idle_bits) == '0)
    else $error("pressed key not idle");

  // No result is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind key_press_long_press_detector_core kplpd_checker #(.KEY_COUNT(KEY_COUNT)) u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

FILE: bench/key_press_long_press_detector_core_tb.sv
`timescale 1ns / 1ps

module key_press_long_press_detector_core_tb;
  import kplpd_pkg::*;

  localparam int KEYS        = 4;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_LIMIT = 2000;
  localparam int MAX_REPORTS = 50;

  // An index past the register list; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // One result transaction, unpacked into its fields.
  typedef struct packed {
    logic [KEYS-1:0] short_press;
    logic [KEYS-1:0] long_press;
    logic [KEYS-1:0] edge_enabled;
    logic            fast_blink;
    logic            slow_blink;
  } press_res_t;

  // One row of the directed stimulus: a register write or one base tick.
  typedef struct packed {
    logic                  is_write;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic [KEYS-1:0]       edges;
    logic [KEYS-1:0]       rels;
    logic                  has_want;
    press_res_t            want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic [7:0]            in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Copy of the configuration and state of the detector.
  logic [7:0]  pr_tick_div;
  logic [7:0]  pr_bounce;
  logic [7:0]  pr_long;
  logic [9:0]  pr_fast_div;
  logic [15:0] pr_slow_div;
  logic [7:0]  pr_prescale;
  logic [9:0]  pr_fast_cnt;
  logic [15:0] pr_slow_cnt;
  logic [KEYS-1:0] pr_armed;
  logic [7:0]  pr_hold [KEYS];
  logic        pr_fast_lvl;
  logic        pr_slow_lvl;

  press_res_t pending_results[$];
  stim_row_t  directed_rows[$];

  int  err_count     = 0;
  int  ticks_sent    = 0;
  int  results_seen  = 0;
  int  shorts_seen   = 0;
  int  longs_seen    = 0;
  int  cycle_count   = 0;
  int  stall_left    = 0;
  bit  stalls_on     = 1'b1;
  int  key_hold_left [KEYS];

  key_press_long_press_detector_core #(.KEY_COUNT(KEYS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // One divider step: returns the fire flag above the new count.
  function automatic logic [16:0] divider_next(input logic [15:0] cnt, input logic [15:0] lim,
                                               input logic [15:0] mask);
    logic [15:0] nxt;
    nxt = (cnt + 16'd1) & mask;
    if (nxt >= lim) return {1'b1, 16'd0};
    return {1'b0, nxt};
  endfunction

  task automatic reset_detector_model();
    pr_tick_div = SLOW_TICK_DIV_RST;
    pr_bounce   = BOUNCE_RST;
    pr_long     = LONG_PRESS_RST;
    pr_fast_div = FAST_DIV_RST;
    pr_slow_div = SLOW_DIV_RST;
    pr_prescale = '0;
    pr_fast_cnt = '0;
    pr_slow_cnt = '0;
    pr_armed    = '0;
    for (int k = 0; k < KEYS; k++) pr_hold[k] = '0;
    pr_fast_lvl = 1'b0;
    pr_slow_lvl = 1'b0;
  endtask

  task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    case (idx)
      REG_SLOW_TICK_DIV: pr_tick_div = data[7:0];
      REG_BOUNCE:        pr_bounce   = data[7:0];
      REG_LONG_PRESS:    pr_long     = data[7:0];
      REG_FAST_DIV:      pr_fast_div = data[9:0];
      REG_SLOW_DIV:      pr_slow_div = data;
      default: ;
    endcase
  endtask

  // Advance the detector copy by one base tick and return what it reports.
  task automatic judge_tick(input logic [KEYS-1:0] edges, input logic [KEYS-1:0] rels,
                            output press_res_t r);
    logic [16:0] nxt;
    logic        slow_tick;
    logic [7:0]  c;
    r = '0;
    // Edges arm idle keys; an armed key ignores them.
    pr_armed = pr_armed | edges;
    nxt = divider_next({8'd0, pr_prescale}, {8'd0, pr_tick_div}, 16'h00FF);
    slow_tick   = nxt[16];
    pr_prescale = nxt[7:0];
    nxt = divider_next({6'd0, pr_fast_cnt}, {6'd0, pr_fast_div}, 16'h03FF);
    if (nxt[16]) pr_fast_lvl = ~pr_fast_lvl;
    pr_fast_cnt = nxt[9:0];
    nxt = divider_next(pr_slow_cnt, pr_slow_div, 16'hFFFF);
    if (nxt[16]) pr_slow_lvl = ~pr_slow_lvl;
    pr_slow_cnt = nxt[15:0];
    // Each armed key counts and is judged on a slow tick.
    for (int k = 0; k < KEYS; k++) begin
      if (slow_tick && pr_armed[k]) begin
        c = pr_hold[k];
        if (c != 8'hFF) c = c + 8'd1;
        pr_hold[k] = c;
        if (c > pr_bounce) begin
          if (rels[k] && c < pr_long) begin
            r.short_press[k] = 1'b1;
            pr_armed[k] = 1'b0;
            pr_hold[k]  = '0;
          end else if (c >= pr_long) begin
            r.long_press[k] = 1'b1;
            pr_armed[k] = 1'b0;
            pr_hold[k]  = '0;
          end
        end else if (c == pr_bounce && rels[k]) begin
          // A release right at the bounce count is a glitch: no result.
          pr_armed[k] = 1'b0;
          pr_hold[k]  = '0;
        end
      end
    end
    r.edge_enabled = ~pr_armed;
    r.fast_blink   = pr_fast_lvl;
    r.slow_blink   = pr_slow_lvl;
  endtask

  // Send one base tick; the prediction is queued when the transaction is taken.
  task automatic send_tick(input logic [KEYS-1:0] edges, input logic [KEYS-1:0] rels,
                           input bit idle_ok, input bit has_want, input press_res_t want);
    press_res_t predicted;
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {rels, edges};
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    judge_tick(edges, rels, predicted);
    pending_results.push_back(has_want ? want : predicted);
    ticks_sent++;
  endtask

  // Register write, made only once every result of earlier ticks has come back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    apply_reg_write(idx, data);
  endtask

  task automatic add_tick(input logic [3:0] edges, input logic [3:0] rels);
    stim_row_t row;
    row = '0;
    row.edges = edges;
    row.rels  = rels;
    directed_rows.push_back(row);
  endtask

  task automatic add_tick_want(input logic [3:0] edges, input logic [3:0] rels,
                               input press_res_t want);
    stim_row_t row;
    row = '0;
    row.edges    = edges;
    row.rels     = rels;
    row.has_want = 1'b1;
    row.want     = want;
    directed_rows.push_back(row);
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    stim_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.reg_data = data;
    directed_rows.push_back(row);
  endtask

  // One random phase: program all registers, then send key press sequences.
  // Most ticks follow whole presses (edge, hold, release) with lengths aimed
  // around the bounce and long thresholds; a few bits are flipped as noise.
  task automatic run_phase(input int tick_div, input int bounce, input int longp,
                           input int fast_div, input int slow_div, input int n_items,
                           input bit idle_ok);
    logic [KEYS-1:0] edges;
    logic [KEYS-1:0] rels;
    int d;
    int top;
    int h;
    write_reg(REG_SLOW_TICK_DIV, 16'(tick_div));
    write_reg(REG_BOUNCE,        16'(bounce));
    write_reg(REG_LONG_PRESS,    16'(longp));
    write_reg(REG_FAST_DIV,      16'(fast_div));
    write_reg(REG_SLOW_DIV,      16'(slow_div));
    stalls_on = idle_ok;
    d   = (tick_div == 0) ? 1 : tick_div;
    top = ((bounce > longp) ? bounce : longp) + 3;
    for (int k = 0; k < KEYS; k++) key_hold_left[k] = 0;
    for (int i = 0; i < n_items; i++) begin
      edges = '0;
      rels  = '0;
      for (int k = 0; k < KEYS; k++) begin
        if (key_hold_left[k] == 0 && $urandom_range(0, 5) == 0) begin
          edges[k] = 1'b1;
          case ($urandom_range(0, 2))
            0: begin
              h = bounce * d + int'($urandom_range(0, 2 * d)) - d;
              key_hold_left[k] = (h < 0) ? 0 : h;
            end
            1: key_hold_left[k] = $urandom_range(bounce * d, longp * d);
            default: key_hold_left[k] = $urandom_range(0, top * d);
          endcase
        end
        rels[k] = (key_hold_left[k] == 0);
        if (key_hold_left[k] > 0) key_hold_left[k]--;
      end
      if ($urandom_range(0, 15) == 0) edges = edges ^ 4'($urandom);
      if ($urandom_range(0, 15) == 0) rels  = rels ^ 4'($urandom);
      send_tick(edges, rels, idle_ok, 1'b0, '0);
    end
  endtask

  // Result side: random stall bursts while enabled.
  always @(negedge clk) begin
    if (stalls_on && stall_left == 0 && $urandom_range(0, 3) == 0)
      stall_left = $urandom_range(1, 3);
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic report_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Compare every result transaction with the oldest prediction.
  always @(posedge clk) begin
    press_res_t got;
    press_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.short_press  = out_tdata[3:0];
      got.long_press   = out_tdata[7:4];
      got.edge_enabled = out_tdata[11:8];
      got.fast_blink   = out_tdata[12];
      got.slow_blink   = out_tdata[13];
      results_seen++;
      shorts_seen += $countones(got.short_press);
      longs_seen  += $countones(got.long_press);
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t ns: unexpected result, expected none, actual %h", $time, out_tdata);
      end else begin
        want = pending_results.pop_front();
        report_field("short_press", want.short_press, got.short_press);
        report_field("long_press", want.long_press, got.long_press);
        report_field("edge_enabled", want.edge_enabled, got.edge_enabled);
        report_field("fast_blink", {3'd0, want.fast_blink}, {3'd0, got.fast_blink});
        report_field("slow_blink", {3'd0, want.slow_blink}, {3'd0, got.slow_blink});
      end
    end
  end

  // Watchdog over the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: run stopped after %0d cycles", $time, CYCLE_LIMIT);
      $display("key_press_long_press_detector_core_tb: FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    int wait_cycles;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = REG_SLOW_TICK_DIV;
    cfg_data   = '0;
    reset_detector_model();

    // Directed rows. Right after reset all keys are idle and no divider fires.
    add_tick_want(4'h0, 4'hF, '{short_press: 4'h0, long_press: 4'h0, edge_enabled: 4'hF,
                               fast_blink: 1'b0, slow_blink: 1'b0});
    add_tick_want(4'hF, 4'h0, '{short_press: 4'h0, long_press: 4'h0, edge_enabled: 4'h0,
                               fast_blink: 1'b0, slow_blink: 1'b0});
    // Fast timing with a zero fast divide; the prescaler limit drops below its count.
    add_write(REG_SLOW_TICK_DIV, 16'd1);
    add_write(REG_BOUNCE,        16'd2);
    add_write(REG_LONG_PRESS,    16'd4);
    add_write(REG_FAST_DIV,      16'd0);
    add_write(REG_SLOW_DIV,      16'd3);
    add_tick(4'h0, 4'h0);
    add_tick(4'hF, 4'h0);   // edges on armed keys
    add_tick(4'h0, 4'h1);   // short press on key 0
    add_tick(4'h0, 4'h2);   // long press even though key 1 is released
    add_tick(4'h3, 4'h0);
    add_tick(4'h0, 4'h3);   // release exactly at the bounce count
    add_tick(4'h4, 4'h4);   // release below the bounce count keeps the key armed
    add_tick(4'h0, 4'h0);
    // Long threshold below the bounce count, and a write to a missing register.
    add_write(REG_BOUNCE,     16'd3);
    add_write(REG_LONG_PRESS, 16'd2);
    add_write(REG_UNUSED,     16'hFFFF);
    add_tick(4'h8, 4'hF);
    add_tick(4'h0, 4'h0);
    add_tick(4'h0, 4'h0);
    add_tick(4'h0, 4'h8);
    add_tick(4'hF, 4'hF);
    // All-ones data: only the register width is kept.
    add_write(REG_SLOW_TICK_DIV, 16'hFFFF);
    add_write(REG_FAST_DIV,      16'hFFFF);
    add_write(REG_SLOW_DIV,      16'hFFFF);
    add_tick(4'h0, 4'hF);
    add_tick(4'hF, 4'hF);
    add_tick(4'hF, 4'h0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_write) write_reg(row.reg_idx, row.reg_data);
      else send_tick(row.edges, row.rels, 1'b1, row.has_want, row.want);
    end

    // Random phases: lowest settings, middle, highest, zero divides with a
    // saturating bounce count, then random settings with no idling at all.
    run_phase(1, 1, 2, 1, 1, 150, 1'b1);
    run_phase(2, 3, 12, 7, 20, 250, 1'b1);
    run_phase(1, 254, 255, 1023, 65535, 300, 1'b1);
    run_phase(0, 255, 255, 0, 0, 250, 1'b1);
    run_phase($urandom_range(1, 4), $urandom_range(1, 8), $urandom_range(2, 20),
              $urandom_range(1, 1023), $urandom_range(1, 300), 150, 1'b0);

    @(negedge clk);
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (5) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t ns: %0d results never arrived, expected 0 outstanding, actual %0d",
               $time, pending_results.size(), pending_results.size());
      err_count += pending_results.size();
    end

    $display("Sent %0d key ticks over nine timing setups; checked %0d results.",
             ticks_sent, results_seen);
    $display("Detected %0d short and %0d long presses; %0d mismatches.",
             shorts_seen, longs_seen, err_count);
    if (err_count == 0) begin
      $display("key_press_long_press_detector_core_tb: PASS");
    end else begin
      $display("key_press_long_press_detector_core_tb: FAIL");
    end
    $finish;
  end

endmodule
